/* src/mmc1_pkg.sv */
// Shared types, codes and helper functions for the MMC1 bank mapper.
// Used by the channel interfaces and by every module of the mapper.
package mmc1_pkg;

	// Field widths.
	localparam int CMD_W   = 2;
	localparam int ADDR_W  = 16;
	localparam int DATA_W  = 8;
	localparam int TGT_W   = 2;
	localparam int MADDR_W = 18;
	localparam int MIRR_W  = 2;
	localparam int BANK_W  = 5;
	localparam int LAST_W  = 4;
	localparam int QDEPTH  = 2;
	localparam int QCNT_W  = $clog2(QDEPTH + 1);
	localparam int QPTR_W  = $clog2(QDEPTH);

	// Bus command codes.
	localparam logic [CMD_W-1:0] CMD_CPU_READ  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CPU_WRITE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PPU_READ  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_PPU_WRITE = 2'd3;

	// Target memory codes.
	localparam logic [TGT_W-1:0] TGT_NONE    = 2'd0;
	localparam logic [TGT_W-1:0] TGT_PRG_ROM = 2'd1;
	localparam logic [TGT_W-1:0] TGT_PRG_RAM = 2'd2;
	localparam logic [TGT_W-1:0] TGT_CHR     = 2'd3;

	// CPU address windows.
	localparam logic [ADDR_W-1:0] RAM_BASE = 16'h6000;
	localparam logic [ADDR_W-1:0] ROM_BASE = 16'h8000;

	// Mapper register selected by address bits 14:13.
	localparam logic [1:0] REG_CONTROL = 2'd0;
	localparam logic [1:0] REG_CHR_LO  = 2'd1;
	localparam logic [1:0] REG_CHR_HI  = 2'd2;
	localparam logic [1:0] REG_PRG     = 2'd3;

	// PRG banking modes from control bits 3:2.
	localparam logic [1:0] PRG_MODE_32K_A  = 2'd0;
	localparam logic [1:0] PRG_MODE_32K_B  = 2'd1;
	localparam logic [1:0] PRG_MODE_FIX_LO = 2'd2;
	localparam logic [1:0] PRG_MODE_FIX_HI = 2'd3;

	// Register reset values and serial constants.
	localparam logic [BANK_W-1:0] SR_EMPTY       = 5'h10;
	localparam logic [BANK_W-1:0] CONTROL_RESET  = 5'h0C;
	localparam logic [BANK_W-1:0] PRG_MODE3_BITS = 5'h0C;
	localparam logic [LAST_W-1:0] LAST_RESET     = 4'hF;

	// Class of an access, decided by the front end.
	typedef enum logic [2:0] {
		CLS_NONE,
		CLS_CHR,
		CLS_RAM,
		CLS_ROM,
		CLS_SERIAL
	} mmc1_cls_t;

	// One classified access as it travels through the queue.
	typedef struct packed {
		mmc1_cls_t          cls;
		logic               wr;
		logic [ADDR_W-1:0]  address;
		logic [DATA_W-1:0]  data;
	} mmc1_op_t;

	// Control register mirroring bits to the iNES-style code.
	function automatic logic [MIRR_W-1:0] mirror_map(input logic [1:0] ctl);
		logic [MIRR_W-1:0] code;
		case (ctl)
			2'd0:    code = 2'd2;
			2'd1:    code = 2'd3;
			2'd2:    code = 2'd1;
			default: code = 2'd0;
		endcase
		return code;
	endfunction

endpackage

/* src/mmc1_if.sv */
// Valid/ready channel interfaces for mapper requests and responses.
// Depends on mmc1_pkg for field widths.
interface mmc1_req_if;
	logic                           valid;
	logic                           ready;
	logic [mmc1_pkg::CMD_W-1:0]     cmd;
	logic [mmc1_pkg::ADDR_W-1:0]    address;
	logic [mmc1_pkg::DATA_W-1:0]    data;

	modport source (output valid, output cmd, output address, output data, input ready);
	modport sink (input valid, input cmd, input address, input data, output ready);
endinterface

interface mmc1_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [mmc1_pkg::TGT_W-1:0]     target;
	logic [mmc1_pkg::MADDR_W-1:0]   mapped_address;
	logic                           write_enable;
	logic [mmc1_pkg::DATA_W-1:0]    write_data;
	logic [mmc1_pkg::MIRR_W-1:0]    mirroring;

	modport source (output valid, output target, output mapped_address, output write_enable,
		output write_data, output mirroring, input ready);
	modport sink (input valid, input target, input mapped_address, input write_enable,
		input write_data, input mirroring, output ready);
endinterface

/* src/mmc1_front.sv */
// Front end: accepts bus accesses and classifies them by command and address.
// Depends on mmc1_pkg and the request interface.
module mmc1_front (
	mmc1_req_if.sink            req,
	output logic                push_valid,
	input  logic                push_ready,
	output mmc1_pkg::mmc1_op_t  push_op
);
	import mmc1_pkg::*;

	// The front end holds no state; a transaction passes when the queue has room.
	assign req.ready  = push_ready;
	assign push_valid = req.valid;

	// Classify the access so the back end only needs the mapper state.
	always_comb begin
		push_op.address = req.address;
		push_op.data    = req.data;
		push_op.wr      = 1'b0;
		if (req.cmd == CMD_PPU_READ || req.cmd == CMD_PPU_WRITE) begin
			push_op.cls = CLS_CHR;
			push_op.wr  = (req.cmd == CMD_PPU_WRITE);
		end else if (req.address < RAM_BASE) begin
			push_op.cls = CLS_NONE;
		end else if (req.address < ROM_BASE) begin
			push_op.cls = CLS_RAM;
			push_op.wr  = (req.cmd == CMD_CPU_WRITE);
		end else if (req.cmd == CMD_CPU_WRITE) begin
			push_op.cls = CLS_SERIAL;
			push_op.wr  = 1'b1;
		end else begin
			push_op.cls = CLS_ROM;
		end
	end

endmodule

/* src/mmc1_queue.sv */
// Two-entry FIFO of classified accesses between the front and back ends.
// Depends on mmc1_pkg for the entry type and depth.
module mmc1_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  mmc1_pkg::mmc1_op_t  push_op,
	output logic                pop_valid,
	input  logic                pop_ready,
	output mmc1_pkg::mmc1_op_t  pop_op
);
	import mmc1_pkg::*;

	mmc1_op_t            entry_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                push;
	logic                pop;

	assign push_ready = (count_q != QCNT_W'(QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_op     = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Entry storage needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* src/mmc1_back.sv */
// Back end: holds the mapper registers, runs the serial loader and translates
// addresses into a registered response. Depends on mmc1_pkg and the response interface.
module mmc1_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [mmc1_pkg::LAST_W-1:0]     cfg_wdata,
	input  logic                            op_valid,
	output logic                            op_ready,
	input  mmc1_pkg::mmc1_op_t              op,
	mmc1_rsp_if.source                      rsp
);
	import mmc1_pkg::*;

	logic [LAST_W-1:0]   last_q;
	logic [BANK_W-1:0]   shift_q, control_q, chr_lo_q, chr_hi_q, prg_q;
	logic [MIRR_W-1:0]   mirror_q;
	logic [BANK_W-1:0]   shift_n, control_n, chr_lo_n, chr_hi_n, prg_n;
	logic [MIRR_W-1:0]   mirror_n;
	logic [BANK_W-1:0]   shifted;
	logic [1:0]          prg_mode;
	logic                upper;
	logic                take;

	logic [TGT_W-1:0]    tgt_c;
	logic [MADDR_W-1:0]  maddr_c;
	logic                we_c;
	logic [DATA_W-1:0]   wd_c;

	logic                valid_q;
	logic [TGT_W-1:0]    tgt_q;
	logic [MADDR_W-1:0]  maddr_q;
	logic                we_q;
	logic [DATA_W-1:0]   wd_q;
	logic [MIRR_W-1:0]   mirr_q;

	// Take the next transaction whenever the output register is free or draining.
	assign op_ready = !valid_q || rsp.ready;
	assign take     = op_valid && op_ready;
	assign prg_mode = control_q[3:2];
	assign upper    = op.address[15] && op.address[14];
	assign shifted  = {op.data[0], shift_q[BANK_W-1:1]};

	// Serial loader: next register values for a mapper register write.
	always_comb begin
		shift_n   = shift_q;
		control_n = control_q;
		chr_lo_n  = chr_lo_q;
		chr_hi_n  = chr_hi_q;
		prg_n     = prg_q;
		mirror_n  = mirror_q;
		if (op.cls == CLS_SERIAL) begin
			if (op.data[7]) begin
				control_n = control_q | PRG_MODE3_BITS;
				shift_n   = SR_EMPTY;
			end else if (shift_q[0]) begin
				shift_n = SR_EMPTY;
				case (op.address[14:13])
					REG_CONTROL: begin
						control_n = shifted;
						mirror_n  = mirror_map(shifted[1:0]);
					end
					REG_CHR_LO: chr_lo_n = shifted;
					REG_CHR_HI: chr_hi_n = shifted;
					default:    prg_n    = shifted;
				endcase
			end else begin
				shift_n = shifted;
			end
		end
	end

	// Address translation from the current register values.
	always_comb begin
		tgt_c   = TGT_NONE;
		maddr_c = '0;
		we_c    = 1'b0;
		wd_c    = '0;
		case (op.cls)
			CLS_CHR: begin
				tgt_c = TGT_CHR;
				if (!control_q[4]) begin
					maddr_c = {1'b0, chr_lo_q[4:1], op.address[12:0]};
				end else if (!op.address[12]) begin
					maddr_c = {1'b0, chr_lo_q, op.address[11:0]};
				end else begin
					maddr_c = {1'b0, chr_hi_q, op.address[11:0]};
				end
				we_c = op.wr;
				wd_c = op.wr ? op.data : '0;
			end
			CLS_RAM: begin
				// Bit 4 of the PRG register switches PRG RAM off.
				if (!prg_q[4]) begin
					tgt_c   = TGT_PRG_RAM;
					maddr_c = {5'b0, op.address[12:0]};
					we_c    = op.wr;
					wd_c    = op.wr ? op.data : '0;
				end
			end
			CLS_ROM: begin
				tgt_c = TGT_PRG_ROM;
				case (prg_mode) inside
					PRG_MODE_32K_A, PRG_MODE_32K_B:
						maddr_c = {prg_q[3:1], op.address[14:0]};
					PRG_MODE_FIX_LO:
						maddr_c = upper ? {prg_q[3:0], op.address[13:0]}
							: {4'b0, op.address[13:0]};
					default:
						maddr_c = upper ? {last_q, op.address[13:0]}
							: {prg_q[3:0], op.address[13:0]};
				endcase
			end
			default: begin
				tgt_c = TGT_NONE;
			end
		endcase
	end

	// Mapper registers and the configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q    <= LAST_RESET;
			shift_q   <= SR_EMPTY;
			control_q <= CONTROL_RESET;
			chr_lo_q  <= '0;
			chr_hi_q  <= '0;
			prg_q     <= '0;
			mirror_q  <= '0;
		end else begin
			if (cfg_we) begin
				last_q <= cfg_wdata;
			end
			if (take) begin
				shift_q   <= shift_n;
				control_q <= control_n;
				chr_lo_q  <= chr_lo_n;
				chr_hi_q  <= chr_hi_n;
				prg_q     <= prg_n;
				mirror_q  <= mirror_n;
			end
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (op_ready) begin
			valid_q <= op_valid;
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (take) begin
			tgt_q   <= tgt_c;
			maddr_q <= maddr_c;
			we_q    <= we_c;
			wd_q    <= wd_c;
			mirr_q  <= mirror_n;
		end
	end

	assign rsp.valid          = valid_q;
	assign rsp.target         = tgt_q;
	assign rsp.mapped_address = maddr_q;
	assign rsp.write_enable   = we_q;
	assign rsp.write_data     = wd_q;
	assign rsp.mirroring      = mirr_q;

endmodule

/* src/mmc1_bank_mapper_unit.sv */
// MMC1 bank mapper: each request transaction is registered first in the two-entry
// queue and then in the back-end output register before its result appears.
// Throughput is one transaction per cycle while the response side is ready; the back end retires one per cycle.
// Reset is asynchronous and active low: queue and output empty, shift register
// empty, control 12, bank registers and mirroring 0, last PRG bank 15.
// Depends on mmc1_pkg, mmc1_if, mmc1_front, mmc1_queue and mmc1_back.
module mmc1_bank_mapper_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [mmc1_pkg::LAST_W-1:0]     cfg_wdata,
	mmc1_req_if.sink                        req,
	mmc1_rsp_if.source                      rsp
);
	import mmc1_pkg::*;

	logic      push_valid, push_ready;
	logic      pop_valid, pop_ready;
	mmc1_op_t  push_op, pop_op;

	// Classification of incoming transactions.
	mmc1_front u_front (
		.req        (req),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_op    (push_op)
	);

	// Decoupling queue.
	mmc1_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_op    (push_op),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_op     (pop_op)
	);

	// Register state and translation.
	mmc1_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.op_valid  (pop_valid),
		.op_ready  (pop_ready),
		.op        (pop_op),
		.rsp       (rsp)
	);

endmodule

/* tb/mmc1_bank_mapper_unit_tb.sv */
// Self-checking testbench for mmc1_bank_mapper_unit: bus accesses go in on the
// request channel and every translated access is checked against a predictor.
// Depends on mmc1_pkg, mmc1_if and the mapper RTL.
module mmc1_bank_mapper_unit_tb;
	import mmc1_pkg::*;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [ADDR_W-1:0] address;
		logic [DATA_W-1:0] data;
	} bus_access_t;

	typedef struct packed {
		logic [TGT_W-1:0]   target;
		logic [MADDR_W-1:0] mapped_address;
		logic               write_enable;
		logic [DATA_W-1:0]  write_data;
		logic [MIRR_W-1:0]  mirroring;
	} mapped_access_t;

	// Control bits 1:0 to the iNES mirroring code.
	localparam logic [MIRR_W-1:0] MIRROR_CODE [4] = '{2'd2, 2'd3, 2'd1, 2'd0};
	localparam int LONG_HOLD_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [LAST_W-1:0] cfg_wdata = '0;

	// Request and response channels, driven from local variables so that
	// every input is known from time zero.
	mmc1_req_if req_ch();
	mmc1_rsp_if rsp_ch();
	logic               drv_valid = 1'b0;
	logic [CMD_W-1:0]   drv_cmd = CMD_CPU_READ;
	logic [ADDR_W-1:0]  drv_address = '0;
	logic [DATA_W-1:0]  drv_data = '0;
	logic               drv_ready = 1'b0;

	assign req_ch.valid   = drv_valid;
	assign req_ch.cmd     = drv_cmd;
	assign req_ch.address = drv_address;
	assign req_ch.data    = drv_data;
	assign rsp_ch.ready   = drv_ready;

	// Mapper state as the predictor sees it.
	logic [BANK_W-1:0] sh_reg;
	logic [BANK_W-1:0] ctl_reg;
	logic [BANK_W-1:0] chr_lo;
	logic [BANK_W-1:0] chr_hi;
	logic [BANK_W-1:0] prg_reg;
	logic [MIRR_W-1:0] mirr_code;
	logic [LAST_W-1:0] last_bank = LAST_RESET;

	bus_access_t    bus_queue[$];
	mapped_access_t expected_maps[$];
	bus_access_t    next_acc;
	mapped_access_t exp_map;
	logic idle_on = 1'b1;
	int src_gap;
	int sink_gap;
	int hold_left;
	int hold_seen;
	int hold_requests = 0;
	int mismatch_count = 0;

	mmc1_bank_mapper_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always #10 clk = ~clk;

	// Translates one bus access and applies its effect on the mapper state.
	function automatic mapped_access_t translate_access(input bus_access_t acc);
		mapped_access_t res;
		logic [BANK_W-1:0] loaded;
		res = '0;
		if (acc.cmd == CMD_PPU_READ || acc.cmd == CMD_PPU_WRITE) begin
			res.target = TGT_CHR;
			if (!ctl_reg[4]) begin
				res.mapped_address = MADDR_W'({chr_lo[4:1], acc.address[12:0]});
			end else if (!acc.address[12]) begin
				res.mapped_address = MADDR_W'({chr_lo, acc.address[11:0]});
			end else begin
				res.mapped_address = MADDR_W'({chr_hi, acc.address[11:0]});
			end
			if (acc.cmd == CMD_PPU_WRITE) begin
				res.write_enable = 1'b1;
				res.write_data = acc.data;
			end
		end else if (acc.address < RAM_BASE) begin
			// Nothing lives below the PRG RAM window.
		end else if (acc.address < ROM_BASE) begin
			if (!prg_reg[4]) begin
				res.target = TGT_PRG_RAM;
				res.mapped_address = MADDR_W'(acc.address[12:0]);
				if (acc.cmd == CMD_CPU_WRITE) begin
					res.write_enable = 1'b1;
					res.write_data = acc.data;
				end
			end
		end else if (acc.cmd == CMD_CPU_WRITE) begin
			// Serial port of the mapper registers.
			if (acc.data[7]) begin
				ctl_reg = ctl_reg | PRG_MODE3_BITS;
				sh_reg = SR_EMPTY;
			end else begin
				loaded = {acc.data[0], sh_reg[4:1]};
				if (!sh_reg[0]) begin
					sh_reg = loaded;
				end else begin
					case (acc.address[14:13])
						REG_CONTROL: begin
							ctl_reg = loaded;
							mirr_code = MIRROR_CODE[loaded[1:0]];
						end
						REG_CHR_LO: chr_lo = loaded;
						REG_CHR_HI: chr_hi = loaded;
						default: prg_reg = loaded;
					endcase
					sh_reg = SR_EMPTY;
				end
			end
		end else begin
			res.target = TGT_PRG_ROM;
			case (ctl_reg[3:2])
				PRG_MODE_FIX_LO: begin
					res.mapped_address = acc.address[14]
						? {prg_reg[3:0], acc.address[13:0]} : {4'd0, acc.address[13:0]};
				end
				PRG_MODE_FIX_HI: begin
					res.mapped_address = acc.address[14]
						? {last_bank, acc.address[13:0]} : {prg_reg[3:0], acc.address[13:0]};
				end
				default: res.mapped_address = {prg_reg[3:1], acc.address[14:0]};
			endcase
		end
		res.mirroring = mirr_code;
		return res;
	endfunction

	task automatic push_access(input logic [CMD_W-1:0] c, input logic [ADDR_W-1:0] a,
			input logic [DATA_W-1:0] d);
		bus_access_t acc;
		acc.cmd = c;
		acc.address = a;
		acc.data = d;
		bus_queue.push_back(acc);
	endtask

	// Five serial writes, LSB first, to the register picked by address bits 14:13.
	task automatic push_serial_load(input logic [ADDR_W-1:0] a, input logic [BANK_W-1:0] value);
		for (int i = 0; i < BANK_W; i++) begin
			push_access(CMD_CPU_WRITE, {a[15:13], 13'($urandom)}, {1'b0, 6'($urandom), value[i]});
		end
	endtask

	// Mostly well-formed register loads mixed with ordinary accesses and noise.
	task automatic queue_random_traffic(input int n);
		int queued;
		int pick;
		queued = 0;
		while (queued < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				push_serial_load({1'b1, 2'($urandom), 13'd0}, 5'($urandom));
				queued += BANK_W;
			end else begin
				if (pick < 34) begin
					push_access(CMD_CPU_WRITE, {1'b1, 15'($urandom)}, {1'b1, 7'($urandom)});
				end else if (pick < 54) begin
					push_access(CMD_CPU_READ, {1'b1, 15'($urandom)}, 8'($urandom));
				end else if (pick < 66) begin
					push_access($urandom_range(0, 1) ? CMD_CPU_WRITE : CMD_CPU_READ,
						{3'b011, 13'($urandom)}, 8'($urandom));
				end else if (pick < 74) begin
					push_access($urandom_range(0, 1) ? CMD_CPU_WRITE : CMD_CPU_READ,
						16'($urandom), 8'($urandom));
				end else begin
					push_access($urandom_range(0, 1) ? CMD_PPU_WRITE : CMD_PPU_READ,
						$urandom_range(0, 1) ? 16'($urandom_range(0, 16'h1FFF)) : 16'($urandom),
						8'($urandom));
				end
				queued++;
			end
		end
	endtask

	// Returns once every queued access has been sent and answered.
	task automatic wait_idle();
		do @(posedge clk);
		while (bus_queue.size() != 0 || drv_valid || expected_maps.size() != 0);
	endtask

	task automatic write_last_bank(input logic [LAST_W-1:0] v);
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		last_bank = v;
	endtask

	// Request driver: offers queued accesses and predicts each accepted one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drv_valid <= 1'b0;
			drv_cmd <= CMD_CPU_READ;
			drv_address <= '0;
			drv_data <= '0;
			src_gap = 0;
			sh_reg = SR_EMPTY;
			ctl_reg = CONTROL_RESET;
			chr_lo = '0;
			chr_hi = '0;
			prg_reg = '0;
			mirr_code = '0;
		end else begin
			if (drv_valid && req_ch.ready) begin
				expected_maps.push_back(translate_access({drv_cmd, drv_address, drv_data}));
			end
			if (!drv_valid || req_ch.ready) begin
				if (src_gap > 0) begin
					src_gap--;
					drv_valid <= 1'b0;
				end else if (bus_queue.size() != 0 && idle_on && $urandom_range(0, 7) == 0) begin
					src_gap = $urandom_range(0, 14);
					drv_valid <= 1'b0;
				end else if (bus_queue.size() != 0) begin
					next_acc = bus_queue.pop_front();
					drv_cmd <= next_acc.cmd;
					drv_address <= next_acc.address;
					drv_data <= next_acc.data;
					drv_valid <= 1'b1;
				end else begin
					drv_valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor: checks each transaction and paces the ready signal.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drv_ready <= 1'b0;
			sink_gap = 0;
			hold_left = 0;
			hold_seen = 0;
		end else begin
			if (rsp_ch.valid && drv_ready) begin
				if (expected_maps.size() == 0) begin
					$error("response transaction with no access outstanding");
					mismatch_count++;
				end else begin
					exp_map = expected_maps.pop_front();
					if (rsp_ch.target !== exp_map.target) begin
						$error("target: expected %0d, actual %0d", exp_map.target, rsp_ch.target);
						mismatch_count++;
					end
					if (rsp_ch.mapped_address !== exp_map.mapped_address) begin
						$error("mapped_address: expected %0h, actual %0h",
							exp_map.mapped_address, rsp_ch.mapped_address);
						mismatch_count++;
					end
					if (rsp_ch.write_enable !== exp_map.write_enable) begin
						$error("write_enable: expected %0d, actual %0d",
							exp_map.write_enable, rsp_ch.write_enable);
						mismatch_count++;
					end
					if (rsp_ch.write_data !== exp_map.write_data) begin
						$error("write_data: expected %0h, actual %0h",
							exp_map.write_data, rsp_ch.write_data);
						mismatch_count++;
					end
					if (rsp_ch.mirroring !== exp_map.mirroring) begin
						$error("mirroring: expected %0d, actual %0d",
							exp_map.mirroring, rsp_ch.mirroring);
						mismatch_count++;
					end
				end
			end
			// A long hold-off lets the mapper fill up and push back on requests.
			if (hold_seen != hold_requests) begin
				hold_seen = hold_requests;
				hold_left = LONG_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				drv_ready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				drv_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				sink_gap = $urandom_range(0, 14);
				drv_ready <= 1'b0;
			end else begin
				drv_ready <= 1'b1;
			end
		end
	end

	// Stimulus: directed accesses, then random phases under several last-bank settings.
	initial begin
		logic [LAST_W-1:0] bank;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_access(CMD_CPU_READ, 16'h0000, 8'h00);
		push_access(CMD_CPU_WRITE, 16'h5FFF, 8'hFF);
		push_access(CMD_CPU_READ, 16'h6000, 8'h00);
		push_access(CMD_CPU_WRITE, 16'h7FFF, 8'hA5);
		push_access(CMD_CPU_READ, 16'h8000, 8'h00);
		push_access(CMD_CPU_READ, 16'hFFFF, 8'h00);
		push_access(CMD_PPU_READ, 16'h0000, 8'h00);
		push_access(CMD_PPU_WRITE, 16'h1FFF, 8'h5A);
		push_access(CMD_PPU_READ, 16'hFFFF, 8'h00);
		// Control load: 4KB CHR banks, 32KB PRG window, new mirroring.
		push_serial_load(16'h8000, 5'h12);
		push_access(CMD_CPU_READ, 16'hC000, 8'h00);
		push_access(CMD_PPU_READ, 16'h1000, 8'h00);
		// A sequence cut short by a serial reset, then a PRG load that disables RAM.
		push_access(CMD_CPU_WRITE, 16'hE000, 8'h01);
		push_access(CMD_CPU_WRITE, 16'hE000, 8'h01);
		push_access(CMD_CPU_WRITE, 16'hE000, 8'h80);
		push_serial_load(16'hE000, 5'h1F);
		push_access(CMD_CPU_WRITE, 16'h6000, 8'h3C);
		push_access(CMD_CPU_READ, 16'hBFFF, 8'h00);

		for (int ph = 0; ph < 6; ph++) begin
			wait_idle();
			case (ph)
				0: bank = '0;
				1: bank = '1;
				3: bank = 4'd8;
				default: bank = 4'($urandom);
			endcase
			write_last_bank(bank);
			idle_on = (ph != 3 && ph != 5);
			if (ph == 2) begin
				hold_requests++;
			end
			queue_random_traffic(150);
		end

		wait_idle();
		repeat (4) @(posedge clk);
		if (mismatch_count == 0 && expected_maps.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#5000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
